/* rtl/gtl_pkg.sv */
// ----------------------------------------------------------------------------
// Greek to Latin transliterator package
// Shared types and byte codes for the ISO-8859-7 to Latin transliterator.
// ----------------------------------------------------------------------------
package gtl_pkg;

   localparam int unsigned MAX_RESULTS = 4;

   typedef enum logic [2:0] {
      PEND_NONE = 3'd0,
      PEND_M_UP = 3'd1,
      PEND_M_LO = 3'd2,
      PEND_N_UP = 3'd3,
      PEND_N_LO = 3'd4
   } gtl_pend_type;

   // Result bytes of one input item, first byte in the lowest slot.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] data;
      logic [2:0]                  count;
   } gtl_result_type;

   localparam logic [7:0] CODE_M_UP     = 8'd204;
   localparam logic [7:0] CODE_N_UP     = 8'd205;
   localparam logic [7:0] CODE_M_LO     = 8'd236;
   localparam logic [7:0] CODE_N_LO     = 8'd237;
   localparam logic [7:0] CODE_PI_UP    = 8'd208;
   localparam logic [7:0] CODE_PI_LO    = 8'd240;
   localparam logic [7:0] CODE_TAU_UP   = 8'd212;
   localparam logic [7:0] CODE_TAU_LO   = 8'd244;
   localparam logic [7:0] CODE_XI_UP    = 8'd206;
   localparam logic [7:0] CODE_XI_LO    = 8'd238;
   localparam logic [7:0] CODE_PSI_UP   = 8'd216;
   localparam logic [7:0] CODE_PSI_LO   = 8'd248;
   localparam logic [7:0] CODE_DIA_IQ   = 8'd192;
   localparam logic [7:0] CODE_DIA_YQ   = 8'd224;
   localparam logic [7:0] CODE_DIA_IA   = 8'd250;
   localparam logic [7:0] CODE_DIA_YA   = 8'd251;

   localparam logic [7:0] CODE_ACC_A_UP = 8'd182;
   localparam logic [7:0] CODE_ACC_E_UP = 8'd184;
   localparam logic [7:0] CODE_ACC_H_UP = 8'd185;
   localparam logic [7:0] CODE_ACC_I_UP = 8'd186;
   localparam logic [7:0] CODE_ACC_O_UP = 8'd188;
   localparam logic [7:0] CODE_ACC_Y_UP = 8'd190;
   localparam logic [7:0] CODE_ACC_W_UP = 8'd191;
   localparam logic [7:0] CODE_ACC_A_LO = 8'd220;
   localparam logic [7:0] CODE_ACC_E_LO = 8'd221;
   localparam logic [7:0] CODE_ACC_H_LO = 8'd222;
   localparam logic [7:0] CODE_ACC_I_LO = 8'd223;
   localparam logic [7:0] CODE_ACC_O_LO = 8'd252;
   localparam logic [7:0] CODE_ACC_Y_LO = 8'd253;
   localparam logic [7:0] CODE_ACC_W_LO = 8'd254;

   localparam logic [7:0] CAP_FIRST     = 8'd193;
   localparam logic [7:0] CAP_LAST      = 8'd217;
   localparam logic [7:0] SMALL_FIRST   = 8'd225;
   localparam logic [7:0] SMALL_LAST    = 8'd249;

   localparam logic [7:0] CHAR_APOS     = 8'd39;
   localparam logic [7:0] CHAR_QUOTE    = 8'd34;

   // Plain letters; a zero entry means the byte passes through unchanged.
   localparam logic [7:0] CAP_MAP [25] = '{
      "A", "V", "G", "D", "E", "Z", "H", "8", "I", "K", "L", "M", "N", 8'd0,
      "O", "P", "R", 8'd0, "S", "T", "Y", "F", "X", 8'd0, "W"
   };
   localparam logic [7:0] SMALL_MAP [25] = '{
      "a", "v", "g", "d", "e", "z", "h", "8", "i", "k", "l", "m", "n", 8'd0,
      "o", "p", "r", 8'd0, "s", "t", "y", "f", "x", 8'd0, "w"
   };

endpackage

/* rtl/gtl_decode.sv */
// ----------------------------------------------------------------------------
// Greek to Latin transliterator decoder
// Maps one input byte and the held M/N letter to up to four result bytes.
// ----------------------------------------------------------------------------
module gtl_decode (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              in_byte,
   input  logic                    end_mark,
   output gtl_pkg::gtl_result_type result
);
   import gtl_pkg::*;

   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      count;
      gtl_pend_type    hold;
   } seg_type;

   function automatic seg_type handle_byte(input logic [7:0] b);
      seg_type    s;
      logic [7:0] ofs;
      s.data    = '0;
      s.data[0] = b;
      s.count   = 2'd1;
      s.hold    = PEND_NONE;
      ofs       = 8'd0;
      case (b)
         CODE_M_UP:   begin s.count = 2'd0; s.hold = PEND_M_UP; end
         CODE_M_LO:   begin s.count = 2'd0; s.hold = PEND_M_LO; end
         CODE_N_UP:   begin s.count = 2'd0; s.hold = PEND_N_UP; end
         CODE_N_LO:   begin s.count = 2'd0; s.hold = PEND_N_LO; end
         CODE_XI_UP:  begin s.data = {8'd0, "S", "K"}; s.count = 2'd2; end
         CODE_XI_LO:  begin s.data = {8'd0, "s", "k"}; s.count = 2'd2; end
         CODE_PSI_UP: begin s.data = {8'd0, "S", "P"}; s.count = 2'd2; end
         CODE_PSI_LO: begin s.data = {8'd0, "s", "p"}; s.count = 2'd2; end
         CODE_DIA_IQ: begin s.data = {CHAR_QUOTE, CHAR_APOS, "i"}; s.count = 2'd3; end
         CODE_DIA_YQ: begin s.data = {CHAR_QUOTE, CHAR_APOS, "y"}; s.count = 2'd3; end
         CODE_DIA_IA: begin s.data = {CHAR_APOS, CHAR_APOS, "i"}; s.count = 2'd3; end
         CODE_DIA_YA: begin s.data = {CHAR_APOS, CHAR_APOS, "y"}; s.count = 2'd3; end
         CODE_ACC_A_UP: begin s.data = {8'd0, "A", CHAR_APOS}; s.count = 2'd2; end
         CODE_ACC_E_UP: begin s.data = {8'd0, "E", CHAR_APOS}; s.count = 2'd2; end
         CODE_ACC_H_UP: begin s.data = {8'd0, "H", CHAR_APOS}; s.count = 2'd2; end
         CODE_ACC_I_UP: begin s.data = {8'd0, "I", CHAR_APOS}; s.count = 2'd2; end
         CODE_ACC_O_UP: begin s.data = {8'd0, "O", CHAR_APOS}; s.count = 2'd2; end
         CODE_ACC_Y_UP: begin s.data = {8'd0, "Y", CHAR_APOS}; s.count = 2'd2; end
         CODE_ACC_W_UP: begin s.data = {8'd0, "W", CHAR_APOS}; s.count = 2'd2; end
         CODE_ACC_A_LO: begin s.data = {8'd0, CHAR_APOS, "a"}; s.count = 2'd2; end
         CODE_ACC_E_LO: begin s.data = {8'd0, CHAR_APOS, "e"}; s.count = 2'd2; end
         CODE_ACC_H_LO: begin s.data = {8'd0, CHAR_APOS, "h"}; s.count = 2'd2; end
         CODE_ACC_I_LO: begin s.data = {8'd0, CHAR_APOS, "i"}; s.count = 2'd2; end
         CODE_ACC_O_LO: begin s.data = {8'd0, CHAR_APOS, "o"}; s.count = 2'd2; end
         CODE_ACC_Y_LO: begin s.data = {8'd0, CHAR_APOS, "y"}; s.count = 2'd2; end
         CODE_ACC_W_LO: begin s.data = {8'd0, CHAR_APOS, "w"}; s.count = 2'd2; end
         default: begin
            if (b >= CAP_FIRST && b <= CAP_LAST) begin
               ofs = b - CAP_FIRST;
               if (CAP_MAP[ofs[4:0]] != 8'd0) begin
                  s.data[0] = CAP_MAP[ofs[4:0]];
               end
            end else if (b >= SMALL_FIRST && b <= SMALL_LAST) begin
               ofs = b - SMALL_FIRST;
               if (SMALL_MAP[ofs[4:0]] != 8'd0) begin
                  s.data[0] = SMALL_MAP[ofs[4:0]];
               end
            end
         end
      endcase
      return s;
   endfunction

   gtl_pend_type pending_ff;
   gtl_pend_type pending_in;
   seg_type      seg;
   logic [7:0]   pend_char;
   logic         has_pend;
   logic         merge_m;
   logic         merge_n;

   always_comb begin
      seg       = handle_byte(in_byte);
      pend_char = 8'd0;
      has_pend  = 1'b1;
      case (pending_ff)
         PEND_M_UP: pend_char = "M";
         PEND_M_LO: pend_char = "m";
         PEND_N_UP: pend_char = "N";
         PEND_N_LO: pend_char = "n";
         default:   has_pend  = 1'b0;
      endcase
      merge_m = (pending_ff == PEND_M_UP || pending_ff == PEND_M_LO) &&
                (in_byte == CODE_PI_UP || in_byte == CODE_PI_LO);
      merge_n = (pending_ff == PEND_N_UP || pending_ff == PEND_N_LO) &&
                (in_byte == CODE_TAU_UP || in_byte == CODE_TAU_LO);

      result     = '0;
      pending_in = PEND_NONE;
      if (end_mark) begin
         if (has_pend) begin
            result.data[0] = pend_char;
            result.count   = 3'd1;
         end
      end else if (merge_m) begin
         result.data[0] = (pending_ff == PEND_M_UP) ? "B" : "b";
         result.count   = 3'd1;
      end else if (merge_n) begin
         result.data[0] = (pending_ff == PEND_N_UP) ? "D" : "d";
         result.count   = 3'd1;
      end else if (has_pend) begin
         result.data[0]   = pend_char;
         result.data[3:1] = seg.data;
         result.count     = 3'd1 + {1'b0, seg.count};
         pending_in       = seg.hold;
      end else begin
         result.data[2:0] = seg.data;
         result.count     = {1'b0, seg.count};
         pending_in       = seg.hold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= PEND_NONE;
      end else if (accept) begin
         pending_ff <= pending_in;
      end
   end

endmodule

/* rtl/gtl_serializer.sv */
// ----------------------------------------------------------------------------
// Greek to Latin transliterator result serializer
// Holds the result bytes of one item and sends them one per transfer.
// ----------------------------------------------------------------------------
module gtl_serializer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  gtl_pkg::gtl_result_type result,
   output logic                    can_load,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,  // out_byte
   output logic                    rsp_tlast   // last_of_run
);
   import gtl_pkg::*;

   logic [MAX_RESULTS-1:0][7:0] data_ff;
   logic [MAX_RESULTS-1:0][7:0] data_in;
   logic [2:0]                  cnt_ff;
   logic [2:0]                  cnt_in;
   logic                        fire;

   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_tdata  = data_ff[0];
   assign rsp_tlast  = (cnt_ff == 3'd1);
   assign fire       = rsp_tvalid && rsp_tready;
   assign can_load   = (cnt_ff == 3'd0) || (fire && rsp_tlast);

   always_comb begin
      data_in = data_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         data_in = result.data;
         cnt_in  = result.count;
      end else if (fire) begin
         data_in = {8'd0, data_ff[MAX_RESULTS-1:1]};
         cnt_in  = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4)
      else $error("Result count exceeds four.");

   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load)
      else $error("Result buffer loaded while still holding bytes.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(cnt_ff) && $stable(rsp_tdata)))
      else $error("Pending result changed during a stall.");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (load && result.count != 3'd0) |=> (rsp_tvalid && rsp_tdata == $past(result.data[0])))
      else $error("Loaded result not presented on the next cycle.");

endmodule

/* rtl/greek_to_latin_transliterator_unit.sv */
// ----------------------------------------------------------------------------
// Greek to Latin transliterator
// Converts an ISO-8859-7 byte stream into Latin "greeklish" bytes.
// ----------------------------------------------------------------------------
// The req channel carries one ISO-8859-7 byte per transfer; req_tlast set
// marks the end of the stream and only flushes a held M/m/N/n letter.
// The rsp channel carries one Latin byte per transfer; rsp_tlast is set on
// the final byte that an input transfer produced.
// An input transfer produces zero to four result bytes. The first result
// byte is presented in the cycle after the input transfer. An item with
// n result bytes occupies the result buffer until all n are taken, and no
// new input is accepted meanwhile; a diaeresis code after a held letter
// gives the most, four bytes. Items with no result, such as a held letter,
// are accepted every cycle while the buffer is empty. The next input is
// accepted in the cycle the last buffered byte is taken.
// A stalled receiver holds the current byte and blocks further inputs once
// the buffer is full. Reset empties the buffer and clears the held letter.
// ----------------------------------------------------------------------------
module greek_to_latin_transliterator_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte
   input  logic       req_tlast,   // end_mark
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tlast    // last_of_run
);
   import gtl_pkg::*;

   gtl_result_type result;
   logic           can_load;
   logic           accept;

   assign req_tready = can_load;
   assign accept     = req_tvalid && can_load;

   gtl_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_byte  (req_tdata),
      .end_mark (req_tlast),
      .result   (result)
   );

   gtl_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// Greek to Latin transliterator testbench
// Drives ISO-8859-7 bytes into the transliterator, predicts the Latin output
// bytes with an independent model of the mapping and the held M/m/N/n letter,
// and checks every output transfer in order. Directed cases come first, then
// random text under several idle and stall patterns and a long receiver
// hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb;
   import gtl_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT  = 2000;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES   = 8;

   localparam logic [7:0] UPPER_LATIN [25] = '{
      "A", "V", "G", "D", "E", "Z", "H", "8", "I", "K", "L", "M", "N", 8'd0,
      "O", "P", "R", 8'd0, "S", "T", "Y", "F", "X", 8'd0, "W"
   };
   localparam logic [7:0] LOWER_LATIN [25] = '{
      "a", "v", "g", "d", "e", "z", "h", "8", "i", "k", "l", "m", "n", 8'd0,
      "o", "p", "r", 8'd0, "s", "t", "y", "f", "x", 8'd0, "w"
   };
   localparam logic [7:0] ACCENTED_UPPER [7] = '{
      CODE_ACC_A_UP, CODE_ACC_E_UP, CODE_ACC_H_UP, CODE_ACC_I_UP,
      CODE_ACC_O_UP, CODE_ACC_Y_UP, CODE_ACC_W_UP
   };
   localparam logic [7:0] ACCENTED_LOWER [7] = '{
      CODE_ACC_A_LO, CODE_ACC_E_LO, CODE_ACC_H_LO, CODE_ACC_I_LO,
      CODE_ACC_O_LO, CODE_ACC_Y_LO, CODE_ACC_W_LO
   };
   localparam logic [7:0] ACCENT_VOWELS [7] = '{"A", "E", "H", "I", "O", "Y", "W"};
   localparam logic [7:0] ACCENT_VOWELS_LO [7] = '{"a", "e", "h", "i", "o", "y", "w"};
   localparam logic [7:0] HELD_CODES [4] = '{CODE_M_UP, CODE_M_LO, CODE_N_UP, CODE_N_LO};
   localparam logic [7:0] JOIN_CODES [4] = '{CODE_PI_UP, CODE_PI_LO, CODE_TAU_UP, CODE_TAU_LO};
   localparam logic [7:0] DIAERESIS_CODES [4] = '{
      CODE_DIA_IQ, CODE_DIA_YQ, CODE_DIA_IA, CODE_DIA_YA
   };

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } latin_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;   // in_byte
   logic       req_tlast = 1'b0;   // end_mark
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // out_byte
   logic       rsp_tlast;          // last_of_run

   latin_byte_type expected_latin [$];
   gtl_pend_type   held_letter = PEND_NONE;

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   logic        hold_off_armed     = 1'b0;
   logic        hold_off_done      = 1'b0;
   int unsigned hold_off_count     = 0;

   int unsigned items_sent      = 0;
   int unsigned end_marks_sent  = 0;
   int unsigned letters_joined  = 0;
   int unsigned results_checked = 0;
   int unsigned mismatches      = 0;
   int unsigned quiet_cycles    = 0;

   greek_to_latin_transliterator_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] held_char(input gtl_pend_type letter);
      case (letter)
         PEND_M_UP: return "M";
         PEND_M_LO: return "m";
         PEND_N_UP: return "N";
         default:   return "n";
      endcase
   endfunction

   function automatic void transliterate(input logic [7:0] code, input logic stream_end);
      logic [7:0]     outs [$];
      gtl_pend_type   was;
      latin_byte_type entry;
      was = held_letter;
      held_letter = PEND_NONE;
      if (stream_end) begin
         if (was != PEND_NONE) outs.push_back(held_char(was));
      end else if ((was == PEND_M_UP || was == PEND_M_LO) &&
                   (code == CODE_PI_UP || code == CODE_PI_LO)) begin
         outs.push_back(was == PEND_M_UP ? "B" : "b");
         letters_joined++;
      end else if ((was == PEND_N_UP || was == PEND_N_LO) &&
                   (code == CODE_TAU_UP || code == CODE_TAU_LO)) begin
         outs.push_back(was == PEND_N_UP ? "D" : "d");
         letters_joined++;
      end else begin
         if (was != PEND_NONE) outs.push_back(held_char(was));
         case (code)
            CODE_M_UP:   held_letter = PEND_M_UP;
            CODE_M_LO:   held_letter = PEND_M_LO;
            CODE_N_UP:   held_letter = PEND_N_UP;
            CODE_N_LO:   held_letter = PEND_N_LO;
            CODE_XI_UP:  begin outs.push_back("K"); outs.push_back("S"); end
            CODE_PSI_UP: begin outs.push_back("P"); outs.push_back("S"); end
            CODE_XI_LO:  begin outs.push_back("k"); outs.push_back("s"); end
            CODE_PSI_LO: begin outs.push_back("p"); outs.push_back("s"); end
            CODE_DIA_IQ: begin
               outs.push_back("i"); outs.push_back(CHAR_APOS); outs.push_back(CHAR_QUOTE);
            end
            CODE_DIA_YQ: begin
               outs.push_back("y"); outs.push_back(CHAR_APOS); outs.push_back(CHAR_QUOTE);
            end
            CODE_DIA_IA: begin
               outs.push_back("i"); outs.push_back(CHAR_APOS); outs.push_back(CHAR_APOS);
            end
            CODE_DIA_YA: begin
               outs.push_back("y"); outs.push_back(CHAR_APOS); outs.push_back(CHAR_APOS);
            end
            default: begin
               if (code >= CAP_FIRST && code <= CAP_LAST &&
                   UPPER_LATIN[int'(code - CAP_FIRST)] != 8'd0) begin
                  outs.push_back(UPPER_LATIN[int'(code - CAP_FIRST)]);
               end else if (code >= SMALL_FIRST && code <= SMALL_LAST &&
                            LOWER_LATIN[int'(code - SMALL_FIRST)] != 8'd0) begin
                  outs.push_back(LOWER_LATIN[int'(code - SMALL_FIRST)]);
               end else begin
                  for (int i = 0; i < 7; i++) begin
                     if (code == ACCENTED_UPPER[i]) begin
                        outs.push_back(CHAR_APOS);
                        outs.push_back(ACCENT_VOWELS[i]);
                     end else if (code == ACCENTED_LOWER[i]) begin
                        outs.push_back(ACCENT_VOWELS_LO[i]);
                        outs.push_back(CHAR_APOS);
                     end
                  end
                  if (outs.size() == 0 || (was != PEND_NONE && outs.size() == 1))
                     outs.push_back(code);
               end
            end
         endcase
      end
      foreach (outs[i]) begin
         entry.out_byte    = outs[i];
         entry.last_of_run = (i == outs.size() - 1);
         expected_latin.push_back(entry);
      end
   endfunction

   function automatic logic [7:0] greek_byte();
      case ($urandom_range(5))
         0: return 8'($urandom_range(CAP_LAST, CAP_FIRST));
         1: return 8'($urandom_range(SMALL_LAST, SMALL_FIRST));
         2: return $urandom_range(1) ? ACCENTED_UPPER[$urandom_range(6)]
                                     : ACCENTED_LOWER[$urandom_range(6)];
         3: return DIAERESIS_CODES[$urandom_range(3)];
         4: return JOIN_CODES[$urandom_range(3)];
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_item(input logic [7:0] code, input logic stream_end);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      req_tlast  <= stream_end;
      do @(posedge clock); while (!req_tready);
      transliterate(code, stream_end);
      items_sent++;
      if (stream_end) end_marks_sent++;
   endtask

   task automatic send_random_item();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 30) begin
         send_item(HELD_CODES[$urandom_range(3)], 1'b0);
         if (pick < 18)
            send_item(JOIN_CODES[$urandom_range(3)], 1'b0);
         else if (pick < 22)
            send_item(8'($urandom_range(255)), 1'b1);
         else if (pick < 25)
            send_item(HELD_CODES[$urandom_range(3)], 1'b0);
         else
            send_item(greek_byte(), 1'b0);
      end else if (pick < 36) begin
         send_item(8'($urandom_range(255)), 1'b1);
      end else begin
         send_item(greek_byte(), 1'b0);
      end
   endtask

   task automatic finish_phase();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_latin.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_plain_bytes();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_item(8'd0, 1'b0);
      send_item(8'd255, 1'b0);
      send_item(CAP_FIRST, 1'b0);
      send_item(SMALL_LAST, 1'b0);
      send_item(8'd210, 1'b0);
      send_item(8'd242, 1'b0);
      finish_phase();
   endtask

   task automatic test_multi_byte_codes();
      send_item(CODE_XI_UP, 1'b0);
      send_item(CODE_PSI_LO, 1'b0);
      foreach (DIAERESIS_CODES[i]) send_item(DIAERESIS_CODES[i], 1'b0);
      send_item(CODE_ACC_A_UP, 1'b0);
      send_item(CODE_ACC_W_LO, 1'b0);
      finish_phase();
   endtask

   task automatic test_held_letters();
      send_item(8'd255, 1'b1);
      send_item(CODE_M_UP, 1'b0);
      send_item(CODE_PI_LO, 1'b0);
      send_item(CODE_N_LO, 1'b0);
      send_item(CODE_TAU_UP, 1'b0);
      send_item(CODE_M_LO, 1'b0);
      send_item(CODE_TAU_LO, 1'b0);
      send_item(CODE_N_UP, 1'b0);
      send_item(CODE_M_LO, 1'b0);
      send_item(8'd0, 1'b1);
      send_item(CODE_M_UP, 1'b0);
      send_item(CODE_DIA_YA, 1'b0);
      finish_phase();
   endtask

   task automatic test_random_text(input int unsigned count, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
      int unsigned target;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      target = items_sent + count;
      while (items_sent < target) send_random_item();
      finish_phase();
   endtask

   task automatic test_output_backpressure();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_armed     = 1'b1;
      for (int i = 0; i < 15; i++) begin
         send_item(HELD_CODES[$urandom_range(3)], 1'b0);
         send_item(DIAERESIS_CODES[$urandom_range(3)], 1'b0);
      end
      finish_phase();
   endtask

   always @(negedge clock) begin
      if (hold_off_armed && !hold_off_done) begin
         rsp_tready <= 1'b0;
         hold_off_count <= hold_off_count + 1;
         if (hold_off_count + 1 == HOLD_OFF_CYCLES) hold_off_done <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      latin_byte_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (expected_latin.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected output transfer: byte %0d last %0b",
                           rsp_tdata, rsp_tlast);
            end else begin
               want = expected_latin.pop_front();
               if (rsp_tdata !== want.out_byte || rsp_tlast !== want.last_of_run) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected byte %0d last %0b, got byte %0d last %0b",
                              want.out_byte, want.last_of_run, rsp_tdata, rsp_tlast);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles.", WATCHDOG_LIMIT);
            $display("** greek_to_latin_transliterator_unit: FAILED **");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_plain_bytes();
      test_multi_byte_codes();
      test_held_letters();
      test_random_text(120, 0, 0);
      test_random_text(100, 84, 0);
      test_random_text(100, 0, 84);
      test_random_text(100, 26, 26);
      test_output_backpressure();
      $display("Sent %0d input transfers (%0d end of stream, %0d held letters joined).",
               items_sent, end_marks_sent, letters_joined);
      $display("Checked %0d output transfers under idle, stall and hold-off patterns.",
               results_checked);
      if (mismatches == 0 && expected_latin.size() == 0)
         $display("** greek_to_latin_transliterator_unit: PASSED **");
      else
         $display("** greek_to_latin_transliterator_unit: FAILED **");
      $finish;
   end

endmodule
